// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rs is high
`define BPTC_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while rs is high
`define BPTC_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hdl/bptc_pkg.sv =====
// Types, constants and helper functions of the pressure/temperature compensation block.
// Depends on nothing; imported by every module of the block.
package bptc_pkg;

  localparam int unsigned DW   = 32;
  localparam int unsigned UP_W = 19;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_OSS     = 3'd0,
    REG_AC1_AC2 = 3'd1,
    REG_AC3_AC4 = 3'd2,
    REG_AC5_AC6 = 3'd3,
    REG_B1_B2   = 3'd4,
    REG_MC_MD   = 3'd5
  } reg_index_t;

  localparam logic [1:0]    OSS_RESET   = 2'd1;
  localparam logic [31:0]   TEMP_OFFSET = 32'd4000;
  localparam logic [31:0]   B4_OFFSET   = 32'd32768;
  localparam logic [31:0]   P_SCALE     = 32'd50000;
  localparam logic [31:0]   SIGN_BIT    = 32'h8000_0000;
  localparam logic [31:0]   C_3038      = 32'd3038;
  localparam logic [31:0]   C_M7357     = 32'hFFFF_E343;
  localparam logic [31:0]   C_3791      = 32'd3791;
  localparam logic [31:0]   P_MAX       = 32'd262143;
  localparam logic [31:0]   T_MAX       = 32'sd32767;
  localparam logic [31:0]   T_MIN       = 32'hFFFF_8000;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [7:0]  pressure_high_byte;
    logic [7:0]  pressure_mid_byte;
    logic [7:0]  pressure_low_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [17:0]        pressure_pascal;
    logic               divide_error;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  oss;
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
  } cal_regs_t;

  // Word handed from the front to the back through the queue
  typedef struct packed {
    logic [UP_W-1:0] up;
    logic [31:0]     x1;
  } fe_item_t;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
    asr32 = $unsigned($signed(v) >>> n);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] zext16(input logic [15:0] v);
    zext16 = {16'd0, v};
  endfunction

endpackage

// ===== hdl/bptc_front.sv =====
// Front part: accepts raw readings, builds the pressure word and the first temperature term.
// Depends on bptc_pkg; feeds bptc_queue.
module bptc_front import bptc_pkg::*; (
  input  logic      in_valid,
  input  in_item_t  in_data,
  input  cal_regs_t cal,
  input  logic      q_full,
  output logic      in_stall,
  output logic      push,
  output fe_item_t  push_item
);

  logic [23:0] raw24;
  logic [23:0] up24;
  logic [31:0] diff;
  logic [31:0] prod;

  // Stall on a full queue only
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Assemble and align the pressure word
  assign raw24 = {in_data.pressure_high_byte, in_data.pressure_mid_byte,
                  in_data.pressure_low_byte};
  always_comb begin
    unique case (cal.oss)
      2'd0:    up24 = raw24 >> 8;
      2'd1:    up24 = raw24 >> 7;
      2'd2:    up24 = raw24 >> 6;
      default: up24 = raw24 >> 5;
    endcase
  end

  // X1 = ((UT - AC6) * AC5) >> 15
  assign diff = zext16(in_data.raw_temperature) - zext16(cal.ac5_ac6[15:0]);
  assign prod = diff * zext16(cal.ac5_ac6[31:16]);

  assign push_item.up = up24[UP_W-1:0];
  assign push_item.x1 = asr32(prod, 15);

endmodule

// ===== hdl/bptc_queue.sv =====
// Short queue between the front and the back parts.
// Depends on bptc_pkg for the item type.
module bptc_queue import bptc_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fe_item_t push_item,
  input  logic     pop,
  output fe_item_t pop_item,
  output logic     empty,
  output logic     full
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  fe_item_t      mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign empty    = (count == '0);
  assign full     = (count == FULL_CNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      if (do_pop)  rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // Store a word
  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_item;
  end

endmodule

// ===== hdl/bptc_div_pipe.sv =====
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
// Depends on bptc_pkg for the data width; carries a sideband word alongside.
module bptc_div_pipe import bptc_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DW-1:0]     dividend,
  input  logic [DW-1:0]     divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DW-1:0]     quotient,
  output logic [SIDE_W-1:0] out_side
);

  localparam int unsigned N = DW;

  logic [N-1:0]      st_vld;
  logic [DW-1:0]     st_rem  [N];
  logic [DW-1:0]     st_dq   [N];
  logic [DW-1:0]     st_div  [N];
  logic [SIDE_W-1:0] st_side [N];
  logic [DW-1:0]     nx_rem  [N];
  logic [DW-1:0]     nx_dq   [N];

  // One trial subtraction per stage
  always_comb begin
    logic [DW-1:0] s_rem;
    logic [DW-1:0] s_dq;
    logic [DW-1:0] s_div;
    logic [DW:0]   sh;
    logic [DW+1:0] df;
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        s_rem = '0;
        s_dq  = dividend;
        s_div = divisor;
      end else begin
        s_rem = st_rem[k-1];
        s_dq  = st_dq[k-1];
        s_div = st_div[k-1];
      end
      sh = {s_rem, s_dq[DW-1]};
      df = {1'b0, sh} - {2'b00, s_div};
      if (!df[DW+1]) begin
        nx_rem[k] = df[DW-1:0];
        nx_dq[k]  = {s_dq[DW-2:0], 1'b1};
      end else begin
        nx_rem[k] = sh[DW-1:0];
        nx_dq[k]  = {s_dq[DW-2:0], 1'b0};
      end
    end
  end

  // Advance the valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      st_vld <= '0;
    end else if (en) begin
      st_vld <= {st_vld[N-2:0], in_valid};
    end
  end

  // Advance the stage data
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N; k++) begin
        st_rem[k] <= nx_rem[k];
        st_dq[k]  <= nx_dq[k];
        if (k == 0) begin
          st_div[k]  <= divisor;
          st_side[k] <= in_side;
        end else begin
          st_div[k]  <= st_div[k-1];
          st_side[k] <= st_side[k-1];
        end
      end
    end
  end

  assign out_valid = st_vld[N-1];
  assign quotient  = st_dq[N-1];
  assign out_side  = st_side[N-1];

endmodule

// ===== hdl/bptc_back.sv =====
// Back part: compensation pipeline with two pipelined dividers and the output register.
// Depends on bptc_pkg and bptc_div_pipe; drains bptc_queue.
module bptc_back import bptc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cal_regs_t cal,
  input  logic      q_empty,
  input  fe_item_t  q_item,
  output logic      q_pop,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  typedef struct packed {
    logic            neg;
    logic [31:0]     x1;
    logic [UP_W-1:0] up;
    logic            err;
  } side1_t;

  typedef struct packed {
    logic        dbl;
    logic [15:0] t;
    logic        err;
  } side2_t;

  logic [31:0] ac1, ac2, ac3, ac4, b1, b2, mc, md;
  logic        en;

  assign ac1 = sext16(cal.ac1_ac2[31:16]);
  assign ac2 = sext16(cal.ac1_ac2[15:0]);
  assign ac3 = sext16(cal.ac3_ac4[31:16]);
  assign ac4 = zext16(cal.ac3_ac4[15:0]);
  assign b1  = sext16(cal.b1_b2[31:16]);
  assign b2  = sext16(cal.b1_b2[15:0]);
  assign mc  = sext16(cal.mc_md[31:16]);
  assign md  = sext16(cal.mc_md[15:0]);

  // Whole pipeline moves when the output register can take a word
  assign en    = !out_valid || !out_stall;
  assign q_pop = en && !q_empty;

  // Stage 0: set up the temperature division
  logic [31:0] den, num, num_abs, den_abs;
  logic        den_zero;
  logic        v0;
  logic [31:0] s0_a, s0_d;
  side1_t      s0_side;

  assign den      = q_item.x1 + md;
  assign den_zero = (den == '0);
  assign num      = mc << 11;
  assign num_abs  = num[31] ? (32'd0 - num) : num;
  assign den_abs  = den_zero ? 32'd1 : (den[31] ? (32'd0 - den) : den);

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= !q_empty;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s0_a         <= num_abs;
      s0_d         <= den_abs;
      s0_side.neg  <= num[31] ^ den[31];
      s0_side.x1   <= q_item.x1;
      s0_side.up   <= q_item.up;
      s0_side.err  <= den_zero;
    end
  end

  logic        d1_valid;
  logic [31:0] d1_q;
  side1_t      d1_side;

  bptc_div_pipe #(.SIDE_W($bits(side1_t))) u_div_t (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v0), .dividend(s0_a), .divisor(s0_d), .in_side(s0_side),
    .out_valid(d1_valid), .quotient(d1_q), .out_side(d1_side)
  );

  // Stage 1: B5, temperature, B6
  logic [31:0] x2t, b5, t32;
  logic [15:0] t_sat;
  logic        v1, e1;
  logic [15:0] t1;
  logic [31:0] b6_1;
  logic [UP_W-1:0] up1;

  assign x2t = d1_side.neg ? (32'd0 - d1_q) : d1_q;
  assign b5  = d1_side.x1 + x2t;
  assign t32 = asr32(b5 + 32'd8, 4);
  always_comb begin
    if ($signed(t32) > $signed(T_MAX))      t_sat = T_MAX[15:0];
    else if ($signed(t32) < $signed(T_MIN)) t_sat = T_MIN[15:0];
    else                                    t_sat = t32[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= d1_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e1   <= d1_side.err;
      t1   <= t_sat;
      b6_1 <= b5 - TEMP_OFFSET;
      up1  <= d1_side.up;
    end
  end

  // Stage 2: square of B6 and the AC2 and AC3 products
  logic        v2, e2;
  logic [15:0] t2;
  logic [31:0] b6_2, sq2, ma2_2, ma3_2;
  logic [UP_W-1:0] up2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e2    <= e1;
      t2    <= t1;
      up2   <= up1;
      b6_2  <= b6_1;
      sq2   <= asr32(b6_1 * b6_1, 12);
      ma2_2 <= asr32(ac2 * b6_1, 11);
      ma3_2 <= asr32(ac3 * b6_1, 13);
    end
  end

  // Stage 3: B2 and B1 products
  logic        v3, e3;
  logic [15:0] t3;
  logic [31:0] ma2_3, ma3_3, xb2_3, xb1_3;
  logic [UP_W-1:0] up3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e3    <= e2;
      t3    <= t2;
      up3   <= up2;
      ma2_3 <= ma2_2;
      ma3_3 <= ma3_2;
      xb2_3 <= asr32(b2 * sq2, 11);
      xb1_3 <= asr32(b1 * sq2, 16);
    end
  end

  // Stage 4: B3 and the B4 term
  logic [31:0] x3a, b3v, b3q;
  logic        v4, e4;
  logic [15:0] t4;
  logic [31:0] b3_4, x3c_4;
  logic [UP_W-1:0] up4;

  assign x3a = xb2_3 + ma2_3;
  assign b3v = (((ac1 << 2) + x3a) << cal.oss) + 32'd2;
  // Truncating divide by four
  assign b3q = asr32(b3v + (b3v[31] ? 32'd3 : 32'd0), 2);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e4    <= e3;
      t4    <= t3;
      up4   <= up3;
      b3_4  <= b3q;
      x3c_4 <= asr32(ma3_3 + xb1_3 + 32'd2, 2);
    end
  end

  // Stage 5: B4 and UP - B3
  logic        v5, e5;
  logic [15:0] t5;
  logic [31:0] b4_5, tmp_5, b4p;

  assign b4p = ac4 * (x3c_4 + B4_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e5    <= e4;
      t5    <= t4;
      b4_5  <= b4p >> 15;
      tmp_5 <= {{(DW-UP_W){1'b0}}, up4} - b3_4;
    end
  end

  // Stage 6: B7
  logic        v6, e6;
  logic [15:0] t6;
  logic [31:0] b4_6, b7_6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e6   <= e5 || (b4_5 == '0);
      t6   <= t5;
      b4_6 <= b4_5;
      b7_6 <= tmp_5 * (P_SCALE >> cal.oss);
    end
  end

  // Stage 7: set up the pressure division
  logic        v7;
  logic [31:0] s7_a, s7_d;
  side2_t      s7_side;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s7_a        <= (b7_6 >= SIGN_BIT) ? b7_6 : (b7_6 << 1);
      s7_d        <= (b4_6 == '0) ? 32'd1 : b4_6;
      s7_side.dbl <= (b7_6 >= SIGN_BIT);
      s7_side.t   <= t6;
      s7_side.err <= e6;
    end
  end

  logic        d2_valid;
  logic [31:0] d2_q;
  side2_t      d2_side;

  bptc_div_pipe #(.SIDE_W($bits(side2_t))) u_div_p (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v7), .dividend(s7_a), .divisor(s7_d), .in_side(s7_side),
    .out_valid(d2_valid), .quotient(d2_q), .out_side(d2_side)
  );

  // Stage 8: restore P and take P >> 8
  logic        v8, e8;
  logic [15:0] t8;
  logic [31:0] p8, x8, pq;

  assign pq = d2_side.dbl ? (d2_q << 1) : d2_q;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= d2_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e8 <= d2_side.err;
      t8 <= d2_side.t;
      p8 <= pq;
      x8 <= asr32(pq, 8);
    end
  end

  // Stage 9: square term and linear term
  logic        v9, e9;
  logic [15:0] t9;
  logic [31:0] p9, m1_9, m2_9;

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= v8;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e9   <= e8;
      t9   <= t8;
      p9   <= p8;
      m1_9 <= x8 * x8;
      m2_9 <= asr32(C_M7357 * p8, 16);
    end
  end

  // Stage 10: scale the square term
  logic        v10, e10;
  logic [15:0] t10;
  logic [31:0] p10, m2_10, m3_10;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      e10   <= e9;
      t10   <= t9;
      p10   <= p9;
      m2_10 <= m2_9;
      m3_10 <= asr32(m1_9 * C_3038, 16);
    end
  end

  // Final sum, saturation and error zeroing into the output register
  logic [31:0] pf;
  logic [17:0] p_sat;

  assign pf = p10 + asr32(m3_10 + m2_10 + C_3791, 4);
  always_comb begin
    if (pf[31])          p_sat = '0;
    else if (pf > P_MAX) p_sat = P_MAX[17:0];
    else                 p_sat = pf[17:0];
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v10;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.temperature_tenths <= e10 ? 16'sd0 : $signed(t10);
      out_data.pressure_pascal    <= e10 ? 18'd0 : p_sat;
      out_data.divide_error       <= e10;
    end
  end

endmodule

// ===== hdl/baro_temp_pressure_compensation_unit.sv =====
// Top level of the barometric temperature/pressure compensation block.
// Depends on bptc_pkg, bptc_front, bptc_queue and bptc_back.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one raw reading: a 16-bit
//   temperature and three pressure bytes. Output channel (out_valid/out_stall/
//   out_data) returns temperature in tenths of a degree, pressure in pascals
//   and a divide error flag. Configuration port (cfg_valid/cfg_ready/
//   cfg_index/cfg_data) writes the oversampling mode and calibration words;
//   it is always ready and should be written only while the block is idle.
//   Throughput: one word per cycle while out_stall is low. The two
//   32-stage pipelined dividers (one quotient bit per stage) and the
//   multiply stages around them lie between acceptance and out_valid.
//   A full queue between the front and the back raises in_stall; a stalled
//   output freezes the whole back pipeline, and the queue absorbs up to
//   QUEUE_DEPTH more words before in_stall rises.
//   Reset (rst, synchronous) empties the queue and pipeline, sets the
//   oversampling mode to 1 and clears the calibration words.
module baro_temp_pressure_compensation_unit import bptc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cal_regs_t cal;
  logic      q_full, q_empty, push, pop;
  fe_item_t  push_item, pop_item;

  assign cfg_ready = 1'b1;

  // Hold configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cal.oss     <= OSS_RESET;
      cal.ac1_ac2 <= '0;
      cal.ac3_ac4 <= '0;
      cal.ac5_ac6 <= '0;
      cal.b1_b2   <= '0;
      cal.mc_md   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OSS:     cal.oss     <= cfg_data[1:0];
        REG_AC1_AC2: cal.ac1_ac2 <= cfg_data;
        REG_AC3_AC4: cal.ac3_ac4 <= cfg_data;
        REG_AC5_AC6: cal.ac5_ac6 <= cfg_data;
        REG_B1_B2:   cal.b1_b2   <= cfg_data;
        REG_MC_MD:   cal.mc_md   <= cfg_data;
        default: ;
      endcase
    end
  end

  bptc_front u_front (
    .in_valid(in_valid), .in_data(in_data), .cal(cal), .q_full(q_full),
    .in_stall(in_stall), .push(push), .push_item(push_item)
  );

  bptc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item),
    .pop(pop), .pop_item(pop_item), .empty(q_empty), .full(q_full)
  );

  bptc_back u_back (
    .clk(clk), .rst(rst), .cal(cal), .q_empty(q_empty), .q_item(pop_item),
    .q_pop(pop), .out_stall(out_stall), .out_valid(out_valid), .out_data(out_data)
  );

endmodule

// ===== hdl/bptc_checker.sv =====
// Port-level checker for the compensation block, bound to the top level.
// Depends on bptc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bptc_checker import bptc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input in_item_t    in_data,
  input logic        out_valid,
  input logic        out_stall,
  input out_item_t   out_data,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // A stalled result word holds
  `BPTC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))

  // A divide error zeroes both results
  `BPTC_ASSERT_IMP(a_err_zero, clk, rst, out_valid && out_data.divide_error, out_data.temperature_tenths == 16'sd0 && out_data.pressure_pascal == 18'd0)

  // Reset empties the pipeline and the queue
  `BPTC_ASSERT_NXT(a_rst_clear, clk, 1'b0, rst, !out_valid && !in_stall)

endmodule

bind baro_temp_pressure_compensation_unit bptc_checker u_bptc_checker (.*);
